>>> rtl/ictf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ictf_pkg
// Types, codes and helpers shared by the INVITE client transaction block.
// ----------------------------------------------------------------------------
package ictf_pkg;

   localparam int TIMER_WIDTH = 22;
   localparam int T1_WIDTH    = 16;
   localparam int CODE_WIDTH  = 10;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int T1_SHIFT    = 6;   // 64 * T1
   localparam int CALC_WIDTH  = (TIMER_WIDTH + 1 > T1_WIDTH + T1_SHIFT) ?
                                (TIMER_WIDTH + 1) : (T1_WIDTH + T1_SHIFT);

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [CALC_WIDTH-1:0]  calc_type;

   localparam calc_type TIMER_MAX = CALC_WIDTH'((64'(1) << TIMER_WIDTH) - 64'(1));

   localparam logic [T1_WIDTH-1:0]   T1_RESET       = T1_WIDTH'(500);
   localparam logic [CODE_WIDTH-1:0] CODE_PROVISIONAL = CODE_WIDTH'(100);
   localparam logic [CODE_WIDTH-1:0] CODE_SUCCESS     = CODE_WIDTH'(200);
   localparam logic [CODE_WIDTH-1:0] CODE_SUCCESS_TOP = CODE_WIDTH'(299);
   localparam logic [CODE_WIDTH-1:0] CODE_FAILURE     = CODE_WIDTH'(300);

   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_CALLING    = 3'd1,
      ST_PROCEEDING = 3'd2,
      ST_COMPLETED  = 3'd3,
      ST_ACCEPTED   = 3'd4,
      ST_TERMINATED = 3'd5
   } txn_state_type;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_RESPONSE = 2'd1,
      ACT_TICK     = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_T1_TICKS = 1'd0,
      CSR_RELIABLE = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [T1_WIDTH-1:0] t1_ticks;
      logic                reliable;
   } cfg_type;

   typedef struct packed {
      txn_state_type state;
      timer_type     retx_remaining;
      timer_type     retx_interval;
      timer_type     timeout_remaining;
      timer_type     linger_remaining;
      timer_type     accepted_remaining;
   } ctx_type;

   typedef struct packed {
      logic          send_request;
      logic          send_ack;
      logic          deliver_response;
      logic          report_timeout;
      txn_state_type state;
   } result_type;

   function automatic timer_type sat_timer(input calc_type v);
      timer_type r;
      if (v > TIMER_MAX) begin
         r = '1;
      end else begin
         r = v[TIMER_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/ictf_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ictf_csr
// Configuration registers: T1 interval and reliable transport flag.
// ----------------------------------------------------------------------------
module ictf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ictf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ictf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output ictf_pkg::cfg_type                    cfg
);
   import ictf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_T1_TICKS: cfg_in.t1_ticks = csr_wdata[T1_WIDTH-1:0];
            CSR_RELIABLE: cfg_in.reliable = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.t1_ticks <= T1_RESET;
         cfg_ff.reliable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/ictf_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ictf_step
// Next transaction state, timers and strobes for one request.
// ----------------------------------------------------------------------------
module ictf_step (
   input  ictf_pkg::cfg_type                  cfg,
   input  ictf_pkg::ctx_type                  ctx_cur,
   input  logic [1:0]                         action,
   input  logic [ictf_pkg::CODE_WIDTH-1:0]    status_code,
   output ictf_pkg::ctx_type                  ctx_nxt,
   output ictf_pkg::result_type               result
);
   import ictf_pkg::*;

   calc_type base_t1;
   calc_type t1_x64;

   assign base_t1 = (cfg.t1_ticks == '0) ? calc_type'(1) : calc_type'(cfg.t1_ticks);
   assign t1_x64  = base_t1 << T1_SHIFT;

   always_comb begin
      ctx_type    c;
      result_type r;
      logic       a_exp;
      logic       b_exp;
      logic       d_exp;
      logic       m_exp;

      c     = ctx_cur;
      r     = '0;
      a_exp = 1'b0;
      b_exp = 1'b0;
      d_exp = 1'b0;
      m_exp = 1'b0;

      case (action)
         ACT_START: begin
            c       = '0;
            c.state = ST_CALLING;
            if (!cfg.reliable) begin
               c.retx_interval  = sat_timer(base_t1);
               c.retx_remaining = c.retx_interval;
            end
            c.timeout_remaining = sat_timer(t1_x64);
            r.send_request      = 1'b1;
         end
         ACT_RESPONSE: begin
            if (c.state == ST_CALLING) begin
               c.state = ST_PROCEEDING;
            end
            case (c.state)
               ST_PROCEEDING: begin
                  if (status_code >= CODE_FAILURE) begin
                     c.state             = ST_COMPLETED;
                     c.retx_remaining    = '0;
                     c.retx_interval     = '0;
                     c.timeout_remaining = '0;
                     c.linger_remaining  = sat_timer(t1_x64);
                     r.send_ack          = 1'b1;
                     r.deliver_response  = 1'b1;
                  end else if (status_code >= CODE_SUCCESS) begin
                     c.state              = ST_ACCEPTED;
                     c.retx_remaining     = '0;
                     c.retx_interval      = '0;
                     c.timeout_remaining  = '0;
                     c.accepted_remaining = sat_timer(t1_x64);
                     r.deliver_response   = 1'b1;
                  end else if (status_code >= CODE_PROVISIONAL) begin
                     r.deliver_response = 1'b1;
                  end
               end
               ST_ACCEPTED: begin
                  r.deliver_response = status_code inside {[CODE_SUCCESS:CODE_SUCCESS_TOP]};
               end
               ST_COMPLETED: begin
                  r.send_ack = (status_code >= CODE_FAILURE);
               end
               default: ;
            endcase
         end
         ACT_TICK: begin
            b_exp = (c.timeout_remaining == TIMER_WIDTH'(1));
            a_exp = (c.retx_remaining == TIMER_WIDTH'(1));
            d_exp = (c.linger_remaining == TIMER_WIDTH'(1));
            m_exp = (c.accepted_remaining == TIMER_WIDTH'(1));
            if (c.timeout_remaining != '0) begin
               c.timeout_remaining = c.timeout_remaining - TIMER_WIDTH'(1);
            end
            if (c.retx_remaining != '0) begin
               c.retx_remaining = c.retx_remaining - TIMER_WIDTH'(1);
            end
            if (c.linger_remaining != '0) begin
               c.linger_remaining = c.linger_remaining - TIMER_WIDTH'(1);
            end
            if (c.accepted_remaining != '0) begin
               c.accepted_remaining = c.accepted_remaining - TIMER_WIDTH'(1);
            end
            if (b_exp && c.state == ST_CALLING) begin
               c                = '0;
               c.state          = ST_TERMINATED;
               r.report_timeout = 1'b1;
            end
            if (a_exp && c.state == ST_CALLING) begin
               c.retx_interval  = sat_timer(calc_type'({c.retx_interval, 1'b0}));
               c.retx_remaining = c.retx_interval;
               r.send_request   = 1'b1;
            end
            if (d_exp && c.state == ST_COMPLETED) begin
               c       = '0;
               c.state = ST_TERMINATED;
            end
            if (m_exp && c.state == ST_ACCEPTED) begin
               c       = '0;
               c.state = ST_TERMINATED;
            end
         end
         default: ;
      endcase

      r.state = c.state;
      ctx_nxt = c;
      result  = r;
   end

endmodule

>>> rtl/invite_client_transaction_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// invite_client_transaction_fsm
// One INVITE client transaction: state, retransmit/timeout/linger/accepted timers
// and the per-request send, ACK, deliver and timeout strobes.
// A request is captured in the input register; the step logic then loads the
//   result register once the result register is empty or rsp_ready is high.
// Throughput: one request per cycle while rsp_ready stays high, through the
//   combinational step logic between the input and result registers.
// Reset (synchronous): state idle, all timers stopped, T1 = 500, unreliable.
// ----------------------------------------------------------------------------
module invite_client_transaction_fsm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_action,
   input  logic [ictf_pkg::CODE_WIDTH-1:0]      req_status_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_send_request,
   output logic                                 rsp_send_ack,
   output logic                                 rsp_deliver_response,
   output logic                                 rsp_report_timeout,
   output logic [2:0]                           rsp_txn_state_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ictf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ictf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import ictf_pkg::*;

   cfg_type    cfg;
   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   result_type step_result;
   result_type rsp_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_action_ff;
   logic [CODE_WIDTH-1:0] in_code_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       step_go;

   ictf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ictf_step u_step (
      .cfg         (cfg),
      .ctx_cur     (ctx_ff),
      .action      (in_action_ff),
      .status_code (in_code_ff),
      .ctx_nxt     (ctx_in),
      .result      (step_result)
   );

   assign step_go   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_go;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (step_go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_code_ff   <= req_status_code;
      end
      if (step_go) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_send_request     = rsp_ff.send_request;
   assign rsp_send_ack         = rsp_ff.send_ack;
   assign rsp_deliver_response = rsp_ff.deliver_response;
   assign rsp_report_timeout   = rsp_ff.report_timeout;
   assign rsp_txn_state_out    = rsp_ff.state;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_timeout_terminates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.report_timeout |-> rsp_ff.state == ST_TERMINATED)
      else $error("timeout reported without termination");

   a_ack_completed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_ack |-> rsp_ff.state == ST_COMPLETED)
      else $error("ACK outside completed state");

   a_terminated_quiet: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.state == ST_TERMINATED |-> ctx_ff.retx_remaining == '0 &&
      ctx_ff.timeout_remaining == '0 && ctx_ff.linger_remaining == '0 &&
      ctx_ff.accepted_remaining == '0)
      else $error("timer running after termination");

   a_retx_has_interval: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.retx_remaining != '0 |-> ctx_ff.retx_interval != '0)
      else $error("retransmit timer running with zero interval");

endmodule
